@@ hw/rtl/tmu_pkg.sv @@
// ----------------------------------------------------------------------------
// Triangle metrics package
// Widths, constants, the CORDIC arctangent table and shared types of the
// triangle metrics pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package tmu_pkg;

    localparam int DefSideWidth = 16;
    localparam int SideW        = 16;
    localparam int PerimW       = 18;
    localparam int AreaW        = 23;
    localparam int AngW         = 16;
    localparam int TolW         = 24;
    localparam int SqW          = 32;
    localparam int XW           = 35;
    localparam int PW           = 66;
    localparam int RootW        = 59;
    localparam int RemW         = 62;
    localparam int SqSteps      = 59;
    localparam int RootShift    = 26;
    localparam int CorSteps     = 29;
    localparam int CorW         = 63;
    localparam int ZW           = 32;
    localparam int DegShift     = 22;
    localparam int DivSteps     = 16;
    localparam int Lanes        = 3;

    localparam logic [TolW-1:0] TolReset = 24'd655;
    localparam logic [AngW-1:0] AngMax   = 16'd46080;
    localparam logic [ZW-1:0]   Deg90    = 32'd90 << DegShift;

    typedef struct packed {
        logic                       ok;
        logic                       right;
        logic [PerimW-1:0]          perim;
        logic [Lanes-1:0][SideW-1:0] side;
        logic [Lanes-1:0][XW-1:0]   x;
    } t_side;

    typedef struct packed {
        logic                        ok;
        logic                        right;
        logic [PerimW-1:0]           perim;
        logic [AreaW-1:0]            area;
        logic [Lanes-1:0][SideW-1:0] side;
        logic [Lanes-1:0]            sat;
        logic [Lanes-1:0][SideW-1:0] low;
    } t_post;

    function automatic logic [ZW-1:0] atan_deg(input int i);
        logic [ZW-1:0] v;
        unique case (i)
            0:  v = 32'd188743680;
            1:  v = 32'd111421900;
            2:  v = 32'd58872272;
            3:  v = 32'd29884485;
            4:  v = 32'd15000234;
            5:  v = 32'd7507429;
            6:  v = 32'd3754631;
            7:  v = 32'd1877430;
            8:  v = 32'd938729;
            9:  v = 32'd469366;
            10: v = 32'd234683;
            11: v = 32'd117342;
            12: v = 32'd58671;
            13: v = 32'd29335;
            14: v = 32'd14668;
            15: v = 32'd7334;
            16: v = 32'd3667;
            17: v = 32'd1833;
            18: v = 32'd917;
            19: v = 32'd458;
            20: v = 32'd229;
            21: v = 32'd115;
            22: v = 32'd57;
            23: v = 32'd29;
            24: v = 32'd14;
            25: v = 32'd7;
            26: v = 32'd4;
            27: v = 32'd2;
            28: v = 32'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Shift toward zero: the magnitude is shifted, then the sign restored.
    function automatic logic [CorW-1:0] sdown(input logic [CorW-1:0] v, input int s);
        logic [CorW-1:0] m;
        m = v[CorW-1] ? CorW'(-v) : v;
        m = m >> s;
        return v[CorW-1] ? CorW'(-m) : m;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/triangle_metrics_unit.sv @@
// ----------------------------------------------------------------------------
// Triangle metrics unit
// Pulse start with three Q8.8 sides whenever busy is low; busy is high only
// during reset, so one item is taken every clock. Each item gives one result
// strobe on o_result_valid, after five stages of squaring and product,
// a 59-stage square root and
// 29 CORDIC stages that also carry the 16-step height divisions, plus entry
// and output registers. The receiver cannot stall and must take every strobe.
// The user must write the tolerance register through the cfg channel only
// while no items are in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_metrics_unit #(
    parameter int SIDE_WIDTH = tmu_pkg::DefSideWidth
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [tmu_pkg::TolW-1:0]     i_cfg_data,
    input  logic [tmu_pkg::SideW-1:0]    i_side_a,
    input  logic [tmu_pkg::SideW-1:0]    i_side_b,
    input  logic [tmu_pkg::SideW-1:0]    i_side_c,
    output logic                         o_result_valid,
    output logic                         o_is_valid,
    output logic                         o_is_right,
    output logic [tmu_pkg::PerimW-1:0]   o_perimeter_len,
    output logic [tmu_pkg::AreaW-1:0]    o_area_value,
    output logic [tmu_pkg::AngW-1:0]     o_angle_opposite_c,
    output logic [tmu_pkg::AngW-1:0]     o_angle_opposite_b,
    output logic [tmu_pkg::AngW-1:0]     o_angle_opposite_a,
    output logic [tmu_pkg::SideW-1:0]    o_height_to_a,
    output logic [tmu_pkg::SideW-1:0]    o_height_to_b,
    output logic [tmu_pkg::SideW-1:0]    o_height_to_c
);
    import tmu_pkg::*;

    localparam int MaskW = (SIDE_WIDTH < SideW) ? SIDE_WIDTH : SideW;
    localparam logic [SideW-1:0] SideMask = SideW'((33'd1 << MaskW) - 33'd1);

    logic            r_busy;
    logic [TolW-1:0] r_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_tol  <= TolReset;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_tol <= i_cfg_data;
            end
        end
    end

    assign busy        = r_busy;
    assign o_cfg_ready = ~r_busy;

    // Stage 1: squares, sums and the triangle inequality.
    logic              n_accept;
    logic [SideW-1:0]  n_a, n_b, n_c, n_big;
    logic [PerimW-1:0] n_sum;
    logic              n_ok;

    always_comb begin
        n_accept = start & ~r_busy;
        n_a      = i_side_a & SideMask;
        n_b      = i_side_b & SideMask;
        n_c      = i_side_c & SideMask;
        n_big    = (n_a > n_b) ? n_a : n_b;
        if (n_c > n_big) begin
            n_big = n_c;
        end
        n_sum = PerimW'(n_a) + PerimW'(n_b) + PerimW'(n_c);
        n_ok  = (n_sum - PerimW'(n_big)) > PerimW'(n_big);
    end

    logic              r1_v, r1_ok;
    logic [SideW-1:0]  r1_a, r1_b, r1_c, r1_dab;
    logic [SqW-1:0]    r1_aa, r1_bb, r1_cc;
    logic [SideW:0]    r1_ab;
    logic [PerimW-1:0] r1_perim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= n_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ok    <= n_ok;
        r1_a     <= n_a;
        r1_b     <= n_b;
        r1_c     <= n_c;
        r1_aa    <= SqW'(n_a) * SqW'(n_a);
        r1_bb    <= SqW'(n_b) * SqW'(n_b);
        r1_cc    <= SqW'(n_c) * SqW'(n_c);
        r1_ab    <= (SideW + 1)'(n_a) + (SideW + 1)'(n_b);
        r1_dab   <= (n_a > n_b) ? n_a - n_b : n_b - n_a;
        r1_perim <= n_sum;
    end

    // Stage 2: outer squares, cosine terms and the right-angle test.
    logic [XW-1:0] n2_xc, n2_xb, n2_xa, n2_abs;

    always_comb begin
        n2_xc  = XW'(r1_aa) + XW'(r1_bb) - XW'(r1_cc);
        n2_xb  = XW'(r1_aa) + XW'(r1_cc) - XW'(r1_bb);
        n2_xa  = XW'(r1_bb) + XW'(r1_cc) - XW'(r1_aa);
        n2_abs = n2_xc[XW-1] ? XW'(-n2_xc) : n2_xc;
    end

    logic           r2_v;
    logic [SqW+1:0] r2_ab2;
    logic [SqW-1:0] r2_dab2, r2_cc;
    t_side          r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_ab2        <= (SqW + 2)'(r1_ab) * (SqW + 2)'(r1_ab);
        r2_dab2       <= SqW'(r1_dab) * SqW'(r1_dab);
        r2_cc         <= r1_cc;
        r2_side.ok    <= r1_ok;
        r2_side.right <= n2_abs < XW'(r_tol);
        r2_side.perim <= r1_perim;
        r2_side.side  <= {r1_c, r1_b, r1_a};
        r2_side.x     <= {n2_xa, n2_xb, n2_xc};
    end

    // Stage 3: the two Heron factors.
    logic           r3_v;
    logic [SqW+1:0] r3_fx;
    logic [SqW-1:0] r3_fy;
    t_side          r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_fx   <= r2_ab2 - (SqW + 2)'(r2_cc);
        r3_fy   <= r2_cc - r2_dab2;
        r3_side <= r2_side;
    end

    // Stage 4: partial products of the 34 by 32 bit product.
    logic             r4_v;
    logic [2*SqW-1:0] r4_plo;
    logic [SqW+1:0]   r4_phi;
    t_side            r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_plo  <= (2 * SqW)'(r3_fx[SqW-1:0]) * (2 * SqW)'(r3_fy);
        r4_phi  <= (SqW + 2)'(r3_fx[SqW+1:SqW]) * (SqW + 2)'(r3_fy);
        r4_side <= r3_side;
    end

    // Stage 5 and the square root pipeline, one root bit per stage.
    logic [PW-1:0]    r_sq_p    [0:SqSteps];
    logic [RemW-1:0]  r_sq_rem  [0:SqSteps];
    logic [RootW-1:0] r_sq_root [0:SqSteps];
    t_side            r_sq_side [0:SqSteps];
    logic [SqSteps:0] r_sq_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else begin
            r_sq_v[0] <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq_p[0]    <= PW'(r4_plo) + {r4_phi, {SqW{1'b0}}};
        r_sq_rem[0]  <= '0;
        r_sq_root[0] <= '0;
        r_sq_side[0] <= r4_side;
    end

    for (genvar j = 0; j < SqSteps; j++) begin : g_sqrt
        localparam int I = SqSteps - 1 - j;
        logic [1:0]      n_pair;
        logic [RemW-1:0] n_t, n_trial;
        logic            n_ge;

        if (I >= RootShift) begin : g_bits
            localparam int Lo = 2 * I - 2 * RootShift;
            assign n_pair = r_sq_p[j][Lo+1:Lo];
        end else begin : g_zero
            assign n_pair = 2'b00;
        end

        assign n_t     = {r_sq_rem[j][RemW-3:0], n_pair};
        assign n_trial = RemW'({r_sq_root[j], 2'b01});
        assign n_ge    = n_t >= n_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[j+1] <= 1'b0;
            end else begin
                r_sq_v[j+1] <= r_sq_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_p[j+1]    <= r_sq_p[j];
            r_sq_rem[j+1]  <= n_ge ? n_t - n_trial : n_t;
            r_sq_root[j+1] <= {r_sq_root[j][RootW-2:0], n_ge};
            r_sq_side[j+1] <= r_sq_side[j];
        end
    end

    // Entry of the CORDIC and division pipeline.
    logic [CorW-1:0]  r_cx   [0:CorSteps][0:Lanes-1];
    logic [CorW-1:0]  r_cy   [0:CorSteps][0:Lanes-1];
    logic [ZW-1:0]    r_cz   [0:CorSteps][0:Lanes-1];
    logic [SideW:0]   r_drem [0:CorSteps][0:Lanes-1];
    logic [SideW-1:0] r_dq   [0:CorSteps][0:Lanes-1];
    t_post            r_po   [0:CorSteps];
    logic [CorSteps:0] r_po_v;

    logic [RootW-1:0] n_root;
    t_side            n_sd;
    logic [RootW:0]   n_asum;

    assign n_root = r_sq_root[SqSteps];
    assign n_sd   = r_sq_side[SqSteps];
    assign n_asum = (RootW + 1)'(n_root) + ((RootW + 1)'(1) << (RootShift + 9));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_po_v[0] <= 1'b0;
        end else begin
            r_po_v[0] <= r_sq_v[SqSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        r_po[0].ok    <= n_sd.ok;
        r_po[0].right <= n_sd.right;
        r_po[0].perim <= n_sd.perim;
        r_po[0].side  <= n_sd.side;
        r_po[0].area  <= n_asum[RootW] ? {AreaW{1'b1}}
                                       : n_asum[RootW-1:RootShift+10];
    end

    for (genvar l = 0; l < Lanes; l++) begin : g_prep
        logic [CorW-1:0]  n_x0;
        logic [RootW:0]   n_dsum;
        logic [SqW:0]     n_d;
        logic [SideW-1:0] n_s;

        assign n_x0   = {{(CorW - XW - RootShift){n_sd.x[l][XW-1]}}, n_sd.x[l],
                         {RootShift{1'b0}}};
        assign n_s    = n_sd.side[l];
        assign n_dsum = (RootW + 1)'(n_root) + ((RootW + 1)'(n_s) << RootShift);
        assign n_d    = n_dsum[RootW:RootShift+1];

        always_ff @(posedge i_clk) begin
            if (n_x0[CorW-1]) begin
                r_cx[0][l] <= CorW'(n_root);
                r_cy[0][l] <= CorW'(-n_x0);
                r_cz[0][l] <= Deg90;
            end else begin
                r_cx[0][l] <= n_x0;
                r_cy[0][l] <= CorW'(n_root);
                r_cz[0][l] <= '0;
            end
            r_po[0].sat[l] <= n_d >= {1'b0, n_s, {DivSteps{1'b0}}};
            r_po[0].low[l] <= n_d[SideW-1:0];
            r_drem[0][l]   <= n_d[SqW:DivSteps];
            r_dq[0][l]     <= '0;
        end
    end

    for (genvar k = 0; k < CorSteps; k++) begin : g_cor
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_po_v[k+1] <= 1'b0;
            end else begin
                r_po_v[k+1] <= r_po_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_po[k+1] <= r_po[k];
        end

        for (genvar l = 0; l < Lanes; l++) begin : g_lane
            logic [CorW-1:0] n_dx, n_dy;
            logic            n_pos;

            assign n_dx  = sdown(r_cy[k][l], k);
            assign n_dy  = sdown(r_cx[k][l], k);
            assign n_pos = !r_cy[k][l][CorW-1] && (r_cy[k][l] != '0);

            always_ff @(posedge i_clk) begin
                if (n_pos) begin
                    r_cx[k+1][l] <= r_cx[k][l] + n_dx;
                    r_cy[k+1][l] <= r_cy[k][l] - n_dy;
                    r_cz[k+1][l] <= r_cz[k][l] + atan_deg(k);
                end else begin
                    r_cx[k+1][l] <= r_cx[k][l] - n_dx;
                    r_cy[k+1][l] <= r_cy[k][l] + n_dy;
                    r_cz[k+1][l] <= r_cz[k][l] - atan_deg(k);
                end
            end

            if (k < DivSteps) begin : g_div
                logic [SideW:0] n_t;
                logic           n_ge;

                assign n_t  = {r_drem[k][l][SideW-1:0], r_po[k].low[l][DivSteps-1-k]};
                assign n_ge = n_t >= {1'b0, r_po[k].side[l]};

                always_ff @(posedge i_clk) begin
                    r_drem[k+1][l] <= n_ge ? n_t - {1'b0, r_po[k].side[l]} : n_t;
                    r_dq[k+1][l]   <= {r_dq[k][l][SideW-2:0], n_ge};
                end
            end else begin : g_hold
                always_ff @(posedge i_clk) begin
                    r_drem[k+1][l] <= r_drem[k][l];
                    r_dq[k+1][l]   <= r_dq[k][l];
                end
            end
        end
    end

    // Output stage: rounding, clamping and zeroing of invalid triangles.
    t_post                     n_fin;
    logic [Lanes-1:0][AngW-1:0] n_ang;
    logic [Lanes-1:0][SideW-1:0] n_hgt;

    assign n_fin = r_po[CorSteps];

    for (genvar l = 0; l < Lanes; l++) begin : g_fin
        logic [ZW-1:0]       n_z;
        logic [ZW-DegShift+7:0] n_q;

        assign n_z = r_cz[CorSteps][l];
        assign n_q = (ZW - DegShift + 8)'((n_z + (ZW'(1) << (DegShift - 9))) >> (DegShift - 8));

        always_comb begin
            if (!n_fin.ok || n_z[ZW-1]) begin
                n_ang[l] = '0;
            end else if (n_q > (ZW - DegShift + 8)'(AngMax)) begin
                n_ang[l] = AngMax;
            end else begin
                n_ang[l] = n_q[AngW-1:0];
            end
            if (!n_fin.ok) begin
                n_hgt[l] = '0;
            end else if (n_fin.sat[l]) begin
                n_hgt[l] = {SideW{1'b1}};
            end else begin
                n_hgt[l] = r_dq[CorSteps][l];
            end
        end
    end

    logic              r_out_v, r_out_ok, r_out_right;
    logic [PerimW-1:0] r_out_perim;
    logic [AreaW-1:0]  r_out_area;
    logic [Lanes-1:0][AngW-1:0]  r_out_ang;
    logic [Lanes-1:0][SideW-1:0] r_out_hgt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_po_v[CorSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_ok    <= n_fin.ok;
        r_out_right <= n_fin.right;
        r_out_perim <= n_fin.ok ? n_fin.perim : '0;
        r_out_area  <= n_fin.ok ? n_fin.area : '0;
        r_out_ang   <= n_ang;
        r_out_hgt   <= n_hgt;
    end

    assign o_result_valid     = r_out_v;
    assign o_is_valid         = r_out_ok;
    assign o_is_right         = r_out_right;
    assign o_perimeter_len    = r_out_perim;
    assign o_area_value       = r_out_area;
    assign o_angle_opposite_c = r_out_ang[0];
    assign o_angle_opposite_b = r_out_ang[1];
    assign o_angle_opposite_a = r_out_ang[2];
    assign o_height_to_a      = r_out_hgt[0];
    assign o_height_to_b      = r_out_hgt[1];
    assign o_height_to_c      = r_out_hgt[2];

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, 95))
        else $error("Result strobe without an item accepted 95 cycles earlier.");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_is_valid) |->
            (o_perimeter_len == '0 && o_area_value == '0 && o_height_to_a == '0
             && o_height_to_b == '0 && o_height_to_c == '0
             && o_angle_opposite_c == '0))
        else $error("Invalid triangle gave nonzero metrics.");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_angle_opposite_a <= AngMax && o_angle_opposite_b <= AngMax
                            && o_angle_opposite_c <= AngMax))
        else $error("Angle beyond 180 degrees.");

endmodule

`default_nettype wire

@@ tb/triangle_metrics_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Triangle metrics unit testbench
// Drives side triples through the start/busy command port, predicts the
// flags, perimeter, Heron area, angles and heights of every item with an
// independent fixed-point calculation, and checks each result strobe in order.
// The right-angle tolerance is rewritten between phases while the pipe is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_metrics_unit_tb;

    import tmu_pkg::*;

    typedef struct packed {
        logic              valid;
        logic              right;
        logic [PerimW-1:0] perim;
        logic [AreaW-1:0]  area;
        logic [AngW-1:0]   ang_c;
        logic [AngW-1:0]   ang_b;
        logic [AngW-1:0]   ang_a;
        logic [SideW-1:0]  h_a;
        logic [SideW-1:0]  h_b;
        logic [SideW-1:0]  h_c;
    } t_tri_metrics;

    localparam int WatchLimit = 3000;
    localparam int DrainWait  = 120;

    localparam longint AtanDeg [29] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429, 3754631,
        1877430, 938729, 469366, 234683, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [TolW-1:0]   i_cfg_data;
    logic [SideW-1:0]  i_side_a;
    logic [SideW-1:0]  i_side_b;
    logic [SideW-1:0]  i_side_c;
    logic              o_result_valid;
    logic              o_is_valid;
    logic              o_is_right;
    logic [PerimW-1:0] o_perimeter_len;
    logic [AreaW-1:0]  o_area_value;
    logic [AngW-1:0]   o_angle_opposite_c;
    logic [AngW-1:0]   o_angle_opposite_b;
    logic [AngW-1:0]   o_angle_opposite_a;
    logic [SideW-1:0]  o_height_to_a;
    logic [SideW-1:0]  o_height_to_b;
    logic [SideW-1:0]  o_height_to_c;

    t_tri_metrics    pending_metrics[$];
    logic [TolW-1:0] tol_shadow;
    bit              idle_on;
    int              mismatch_cnt;
    int              item_cnt;
    int              result_cnt;
    int              valid_cnt;
    int              right_cnt;
    int              cfg_cnt;
    int              quiet_cycles;

    triangle_metrics_unit DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_side_a           (i_side_a),
        .i_side_b           (i_side_b),
        .i_side_c           (i_side_c),
        .o_result_valid     (o_result_valid),
        .o_is_valid         (o_is_valid),
        .o_is_right         (o_is_right),
        .o_perimeter_len    (o_perimeter_len),
        .o_area_value       (o_area_value),
        .o_angle_opposite_c (o_angle_opposite_c),
        .o_angle_opposite_b (o_angle_opposite_b),
        .o_angle_opposite_a (o_angle_opposite_a),
        .o_height_to_a      (o_height_to_a),
        .o_height_to_b      (o_height_to_b),
        .o_height_to_c      (o_height_to_c)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic [63:0] wide_root(logic [127:0] n);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int bit_pos = 58; bit_pos >= 0; bit_pos--) begin
            t = r | (64'd1 << bit_pos);
            if (128'(t) * 128'(t) <= n) begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic longint toward_zero(longint v, int s);
        if (v >= 0) begin
            return v >>> s;
        end
        return -((-v) >>> s);
    endfunction

    function automatic logic [AngW-1:0] cordic_angle(longint y, longint x);
        longint z;
        longint t;
        longint nx;
        longint ny;
        longint q;
        z = 0;
        if (x < 0) begin
            t = y;
            y = -x;
            x = t;
            z = longint'(90) << 22;
        end
        for (int i = 0; i < 29; i++) begin
            if (y > 0) begin
                nx = x + toward_zero(y, i);
                ny = y - toward_zero(x, i);
                z += AtanDeg[i];
            end else begin
                nx = x - toward_zero(y, i);
                ny = y + toward_zero(x, i);
                z -= AtanDeg[i];
            end
            x = nx;
            y = ny;
        end
        if (z < 0) begin
            return '0;
        end
        q = (z + (longint'(1) << 13)) >>> 14;
        return (q > 46080) ? AngW'(46080) : AngW'(q);
    endfunction

    function automatic logic [SideW-1:0] height_on(logic [63:0] root, logic [SideW-1:0] s);
        logic [63:0] h;
        if (s == 0) begin
            return '0;
        end
        h = (root + (64'(s) << 26)) / (64'(s) << 27);
        return (h > 65535) ? 16'hFFFF : h[15:0];
    endfunction

    function automatic t_tri_metrics triangle_metrics(logic [SideW-1:0] a, logic [SideW-1:0] b,
                                                      logic [SideW-1:0] c, logic [TolW-1:0] tol);
        t_tri_metrics m;
        longint       aa;
        longint       bb;
        longint       cc;
        longint       diff;
        longint       big;
        longint       rest;
        longint       ab;
        longint       dab;
        longint       fx;
        longint       fy;
        logic [127:0] n;
        logic [63:0]  root;
        logic [63:0]  area;
        aa = longint'(a) * longint'(a);
        bb = longint'(b) * longint'(b);
        cc = longint'(c) * longint'(c);
        diff = cc - (aa + bb);
        if (diff < 0) begin
            diff = -diff;
        end
        big = (a > b) ? longint'(a) : longint'(b);
        if (longint'(c) > big) begin
            big = longint'(c);
        end
        rest = longint'(a) + longint'(b) + longint'(c) - big;
        m = '0;
        m.right = (diff < longint'(tol));
        if (rest > big) begin
            ab = longint'(a) + longint'(b);
            dab = (a > b) ? longint'(a) - longint'(b) : longint'(b) - longint'(a);
            fx = ab * ab - cc;
            fy = cc - dab * dab;
            n = (128'(fx) * 128'(fy)) << 52;
            root = wide_root(n);
            area = (root + (64'd1 << 35)) >> 36;
            m.valid = 1'b1;
            m.perim = PerimW'(ab + longint'(c));
            m.area  = (area > 64'h7FFFFF) ? 23'h7FFFFF : area[22:0];
            m.ang_c = cordic_angle(longint'(root), (aa + bb - cc) <<< 26);
            m.ang_b = cordic_angle(longint'(root), (aa + cc - bb) <<< 26);
            m.ang_a = cordic_angle(longint'(root), (bb + cc - aa) <<< 26);
            m.h_a = height_on(root, a);
            m.h_b = height_on(root, b);
            m.h_c = height_on(root, c);
        end
        return m;
    endfunction

    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send_item(logic [SideW-1:0] a, logic [SideW-1:0] b, logic [SideW-1:0] c);
        bit taken;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_side_a <= a;
        i_side_b <= b;
        i_side_c <= c;
        do begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end while (!taken);
        pending_metrics.push_back(triangle_metrics(a, b, c, tol_shadow));
        item_cnt++;
    endtask

    task automatic drain_pipe();
        start <= 1'b0;
        wait (pending_metrics.size() == 0);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    task automatic write_tolerance(logic [TolW-1:0] value);
        bit taken;
        drain_pipe();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end while (!taken);
        i_cfg_valid <= 1'b0;
        tol_shadow = value;
        cfg_cnt++;
    endtask

    task automatic send_valid_triangle(int unsigned limit);
        int unsigned a;
        int unsigned b;
        int unsigned lo;
        int unsigned hi;
        a = $urandom_range(1, limit);
        b = $urandom_range(1, limit);
        lo = ((a > b) ? a - b : b - a) + 1;
        hi = a + b - 1;
        if (hi > 65535) begin
            hi = 65535;
        end
        if (lo > hi) begin
            lo = hi;
        end
        send_item(SideW'(a), SideW'(b), SideW'($urandom_range(lo, hi)));
    endtask

    task automatic send_near_right();
        int unsigned a;
        int unsigned b;
        int unsigned c;
        a = $urandom_range(1, 40000);
        b = $urandom_range(1, 40000);
        c = 32'(wide_root(128'(a * a + b * b)));
        c = c + $urandom_range(0, 2);
        c = (c > 0) ? c - 1 : 0;
        if ($urandom_range(0, 1)) begin
            send_item(SideW'(a), SideW'(b), SideW'(c));
        end else begin
            send_item(SideW'(b), SideW'(a), SideW'(c));
        end
    endtask

    task automatic test_directed();
        send_item(16'd0, 16'd0, 16'd0);
        send_item(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(16'd1, 16'd1, 16'd1);
        send_item(16'd768, 16'd1024, 16'd1280);
        send_item(16'd1280, 16'd1024, 16'd768);
        send_item(16'd1024, 16'd1280, 16'd768);
        send_item(16'd256, 16'd256, 16'd512);
        send_item(16'd0, 16'd1000, 16'd1000);
        send_item(16'd1000, 16'd0, 16'd1000);
        send_item(16'd1000, 16'd1000, 16'd0);
        send_item(16'd30000, 16'd30000, 16'd59999);
        send_item(16'd65535, 16'd65535, 16'd1);
        send_item(16'd1, 16'd65535, 16'd65535);
        send_item(16'd65535, 16'd1, 16'd65535);
        send_item(16'd3, 16'd4, 16'd5);
        send_item(16'd46341, 16'd46341, 16'd65535);
        send_item(16'd100, 16'd200, 16'd400);
        send_item(16'd40000, 16'd40000, 16'd1);
        send_item(16'hAAAA, 16'h5555, 16'hFFFF);
        send_item(16'h5555, 16'hAAAA, 16'h8000);
    endtask

    task automatic test_tolerance_settings();
        write_tolerance('0);
        for (int i = 0; i < 8; i++) send_near_right();
        send_item(16'd768, 16'd1024, 16'd1280);
        write_tolerance(24'hFFFFFF);
        for (int i = 0; i < 8; i++) send_near_right();
        send_item(16'd0, 16'd0, 16'd4000);
        write_tolerance(24'd1);
        for (int i = 0; i < 8; i++) send_near_right();
        write_tolerance(TolReset);
    endtask

    task automatic test_random(int count);
        int unsigned pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
                send_valid_triangle(($urandom_range(0, 3) == 0) ? 65535 : 1200);
            end else if (pick < 7) begin
                send_near_right();
            end else begin
                send_item(SideW'($urandom), SideW'($urandom), SideW'($urandom));
            end
        end
    endtask

    task automatic test_random_tolerance();
        for (int phase = 0; phase < 3; phase++) begin
            write_tolerance(TolW'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 23)));
            test_random(60);
        end
        write_tolerance(TolReset);
    endtask

    task automatic test_pressure_pause();
        test_random(20);
        drain_pipe();
        test_random(20);
    endtask

    task automatic report_mismatch(string what, longint exp_v, longint act_v);
        mismatch_cnt++;
        if (mismatch_cnt <= 10) begin
            $display("mismatch on result %0d, %s: expected %0d, got %0d",
                     result_cnt, what, exp_v, act_v);
        end
    endtask

    always @(negedge i_clk) begin
        t_tri_metrics exp_m;
        if (i_rst_n && o_result_valid) begin
            if (pending_metrics.size() == 0) begin
                report_mismatch("unexpected result strobe", 0, 1);
            end else begin
                exp_m = pending_metrics.pop_front();
                if (o_is_valid != exp_m.valid) report_mismatch("is_valid", exp_m.valid, o_is_valid);
                if (o_is_right != exp_m.right) report_mismatch("is_right", exp_m.right, o_is_right);
                if (o_perimeter_len != exp_m.perim) begin
                    report_mismatch("perimeter_len", exp_m.perim, o_perimeter_len);
                end
                if (o_area_value != exp_m.area) report_mismatch("area_value", exp_m.area, o_area_value);
                if (o_angle_opposite_c != exp_m.ang_c) begin
                    report_mismatch("angle_opposite_c", exp_m.ang_c, o_angle_opposite_c);
                end
                if (o_angle_opposite_b != exp_m.ang_b) begin
                    report_mismatch("angle_opposite_b", exp_m.ang_b, o_angle_opposite_b);
                end
                if (o_angle_opposite_a != exp_m.ang_a) begin
                    report_mismatch("angle_opposite_a", exp_m.ang_a, o_angle_opposite_a);
                end
                if (o_height_to_a != exp_m.h_a) report_mismatch("height_to_a", exp_m.h_a, o_height_to_a);
                if (o_height_to_b != exp_m.h_b) report_mismatch("height_to_b", exp_m.h_b, o_height_to_b);
                if (o_height_to_c != exp_m.h_c) report_mismatch("height_to_c", exp_m.h_c, o_height_to_c);
                valid_cnt += exp_m.valid;
                right_cnt += exp_m.right;
            end
            result_cnt++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n || o_result_valid || (start && !busy) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WatchLimit) begin
            $display("timeout with %0d results outstanding", pending_metrics.size());
            $display("triangle_metrics_unit_tb NOT OK");
            $finish;
        end
    end

    initial begin
        start        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        i_side_a     = '0;
        i_side_b     = '0;
        i_side_c     = '0;
        tol_shadow   = TolReset;
        idle_on      = 1'b1;
        mismatch_cnt = 0;
        item_cnt     = 0;
        result_cnt   = 0;
        valid_cnt    = 0;
        right_cnt    = 0;
        cfg_cnt      = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_tolerance_settings();
        test_random(350);
        test_pressure_pause();
        test_random_tolerance();
        idle_on = 1'b0;
        test_random(140);
        drain_pipe();

        $display("covered %0d items, %0d results (%0d valid, %0d right), %0d tolerance writes",
                 item_cnt, result_cnt, valid_cnt, right_cnt, cfg_cnt);
        $display("mismatches: %0d", mismatch_cnt);
        if (mismatch_cnt == 0 && pending_metrics.size() == 0) begin
            $display("triangle_metrics_unit_tb OK");
        end else begin
            $display("triangle_metrics_unit_tb NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ triangle_metrics_unit.f @@
hw/rtl/tmu_pkg.sv
hw/rtl/triangle_metrics_unit.sv
tb/triangle_metrics_unit_tb.sv
